@@ sv/mcvp_pkg.sv @@
// ============================================================================
// MIDI channel voice parser - shared package
// Types, message codes and field widths used by the parser and voice stages.
// ============================================================================
`default_nettype none

package mcvp_pkg;

    // Sizing
    localparam int DEFAULT_NUM_CHANNELS = 16;
    localparam int CHAN_W  = 4;
    localparam int DATA_W  = 7;
    localparam int BEND_W  = 14;
    localparam int PITCH_W = 22;

    // Status byte kinds (high nibble)
    localparam logic [3:0] STAT_NOTE_OFF  = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON   = 4'h9;
    localparam logic [3:0] STAT_CTRL      = 4'hB;
    localparam logic [3:0] STAT_PRESSURE  = 4'hD;
    localparam logic [3:0] STAT_BEND      = 4'hE;

    // Controller numbers
    localparam logic [DATA_W-1:0] CC_NRPN_LSB  = 7'h63;
    localparam logic [DATA_W-1:0] CC_NRPN_MSB  = 7'h62;
    localparam logic [DATA_W-1:0] CC_RPN_LSB   = 7'd101;
    localparam logic [DATA_W-1:0] CC_RPN_MSB   = 7'd100;
    localparam logic [DATA_W-1:0] CC_DATA      = 7'h06;
    localparam logic [DATA_W-1:0] CC_EXPRESSION = 7'h0B;

    // NRPN key that marks a tie
    localparam logic [DATA_W-1:0] TIE_KEY_LSB = 7'd9;
    localparam logic [DATA_W-1:0] TIE_KEY_MSB = 7'd71;

    // Reset values
    localparam logic [BEND_W-1:0] BEND_CENTRE      = 14'd8192;
    localparam logic [DATA_W-1:0] BEND_RANGE_RESET = 7'd2;

    // Operation handed from the parser to the voice stage
    typedef enum logic [2:0] {
        OP_NONE,
        OP_NOTE,
        OP_ON_VEL,
        OP_OFF_VEL,
        OP_BEND_LO,
        OP_BEND_HI,
        OP_PRESS,
        OP_TIE
    } voice_opcode_t;

    typedef struct packed {
        voice_opcode_t      opcode;
        logic [CHAN_W-1:0]  chan;
        logic [DATA_W-1:0]  data;
        logic [DATA_W-1:0]  bend_range;
        logic               expr_on;
        logic [DATA_W-1:0]  expr_level;
    } voice_op_t;

    // One entry of the per-channel voice memory
    typedef struct packed {
        logic [DATA_W-1:0] note;
        logic [DATA_W-1:0] volume;
        logic [BEND_W-1:0] bend;
    } voice_entry_t;

    localparam voice_entry_t ENTRY_RESET = '{note: '0, volume: '0, bend: BEND_CENTRE};

endpackage

`default_nettype wire

@@ sv/mcvp_decode.sv @@
// ============================================================================
// MIDI channel voice parser - byte decoder
// Running-status parse state, controller key registers and bend range; issues
// one voice operation per accepted byte.
// ============================================================================
`default_nettype none

module mcvp_decode #(
    parameter int NUM_CHANNELS = mcvp_pkg::DEFAULT_NUM_CHANNELS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic [7:0]        in_byte,
    output mcvp_pkg::voice_op_t    op_o
);

    typedef enum logic [3:0] {
        ST_STATUS   = 4'd0,
        ST_ON_NOTE  = 4'd1,
        ST_ON_VEL   = 4'd2,
        ST_OFF_NOTE = 4'd3,
        ST_OFF_VEL  = 4'd4,
        ST_BEND_LO  = 4'd5,
        ST_BEND_HI  = 4'd6,
        ST_CC_NUM   = 4'd7,
        ST_NRPN_LO  = 4'd9,
        ST_NRPN_HI  = 4'd10,
        ST_DATA     = 4'd11,
        ST_RPN_LO   = 4'd12,
        ST_RPN_HI   = 4'd13,
        ST_PRESS    = 4'd14,
        ST_EXPR     = 4'd15
    } parse_state_t;

    localparam logic [mcvp_pkg::CHAN_W:0] NUM_CH = (mcvp_pkg::CHAN_W+1)'(NUM_CHANNELS);

    parse_state_t                  state_reg, state_next;
    logic [mcvp_pkg::CHAN_W-1:0]   chan_reg, chan_next;
    logic [mcvp_pkg::DATA_W-1:0]   nrpn_lo_reg, nrpn_lo_next;
    logic [mcvp_pkg::DATA_W-1:0]   nrpn_hi_reg, nrpn_hi_next;
    logic [mcvp_pkg::DATA_W-1:0]   rpn_lo_reg, rpn_lo_next;
    logic [mcvp_pkg::DATA_W-1:0]   rpn_hi_reg, rpn_hi_next;
    logic                          registered_reg, registered_next;
    logic [mcvp_pkg::DATA_W-1:0]   range_reg, range_next;
    logic                          expr_on_reg, expr_on_next;
    logic [mcvp_pkg::DATA_W-1:0]   expr_level_reg, expr_level_next;

    logic [mcvp_pkg::DATA_W-1:0]   data;
    logic                          chan_ok;
    mcvp_pkg::voice_opcode_t       opcode;

    assign data    = in_byte[6:0];
    assign chan_ok = {1'b0, chan_reg} < NUM_CH;

    // Next-state and operation decode
    always_comb begin
        state_next      = state_reg;
        chan_next       = chan_reg;
        nrpn_lo_next    = nrpn_lo_reg;
        nrpn_hi_next    = nrpn_hi_reg;
        rpn_lo_next     = rpn_lo_reg;
        rpn_hi_next     = rpn_hi_reg;
        registered_next = registered_reg;
        range_next      = range_reg;
        expr_on_next    = expr_on_reg;
        expr_level_next = expr_level_reg;
        opcode          = mcvp_pkg::OP_NONE;

        if (in_byte[7]) begin
            // status byte: channel always taken, unknown kinds keep the state
            chan_next = in_byte[3:0];
            unique case (in_byte[7:4])
                mcvp_pkg::STAT_NOTE_OFF: state_next = ST_OFF_NOTE;
                mcvp_pkg::STAT_NOTE_ON:  state_next = ST_ON_NOTE;
                mcvp_pkg::STAT_CTRL:     state_next = ST_CC_NUM;
                mcvp_pkg::STAT_PRESSURE: state_next = ST_PRESS;
                mcvp_pkg::STAT_BEND:     state_next = ST_BEND_LO;
                default: ;
            endcase
        end else begin
            unique case (state_reg)
                ST_STATUS: ;
                ST_ON_NOTE: begin
                    opcode     = mcvp_pkg::OP_NOTE;
                    state_next = ST_ON_VEL;
                end
                ST_ON_VEL: begin
                    opcode     = mcvp_pkg::OP_ON_VEL;
                    state_next = ST_ON_NOTE;
                end
                ST_OFF_NOTE: begin
                    opcode     = mcvp_pkg::OP_NOTE;
                    state_next = ST_OFF_VEL;
                end
                ST_OFF_VEL: begin
                    opcode     = mcvp_pkg::OP_OFF_VEL;
                    state_next = ST_OFF_NOTE;
                end
                ST_BEND_LO: begin
                    opcode     = mcvp_pkg::OP_BEND_LO;
                    state_next = ST_BEND_HI;
                end
                ST_BEND_HI: begin
                    opcode     = mcvp_pkg::OP_BEND_HI;
                    state_next = ST_BEND_LO;
                end
                ST_CC_NUM: begin
                    unique case (data)
                        mcvp_pkg::CC_NRPN_LSB:   state_next = ST_NRPN_LO;
                        mcvp_pkg::CC_NRPN_MSB:   state_next = ST_NRPN_HI;
                        mcvp_pkg::CC_RPN_LSB:    state_next = ST_RPN_LO;
                        mcvp_pkg::CC_RPN_MSB:    state_next = ST_RPN_HI;
                        mcvp_pkg::CC_DATA:       state_next = ST_DATA;
                        mcvp_pkg::CC_EXPRESSION: state_next = ST_EXPR;
                        default: ;
                    endcase
                end
                ST_NRPN_LO: begin
                    registered_next = 1'b0;
                    nrpn_lo_next    = data;
                end
                ST_NRPN_HI: begin
                    registered_next = 1'b0;
                    nrpn_hi_next    = data;
                end
                ST_RPN_LO: begin
                    registered_next = 1'b1;
                    rpn_lo_next     = data;
                end
                ST_RPN_HI: begin
                    registered_next = 1'b1;
                    rpn_hi_next     = data;
                end
                ST_DATA: begin
                    // RPN 0/0 sets the bend range, NRPN 9/71 is a tie
                    if (registered_reg && rpn_lo_reg == '0 && rpn_hi_reg == '0) begin
                        range_next = data;
                    end else if (!registered_reg && nrpn_lo_reg == mcvp_pkg::TIE_KEY_LSB
                                 && nrpn_hi_reg == mcvp_pkg::TIE_KEY_MSB) begin
                        opcode = mcvp_pkg::OP_TIE;
                    end
                end
                ST_PRESS: opcode = mcvp_pkg::OP_PRESS;
                ST_EXPR: begin
                    expr_on_next    = 1'b1;
                    expr_level_next = data;
                end
                default: ;
            endcase
        end

        // channels beyond the table leave the voice memory alone
        if (!chan_ok && opcode != mcvp_pkg::OP_TIE) begin
            opcode = mcvp_pkg::OP_NONE;
        end
    end

    // Operation to the voice stage, with settings as they stand before this byte
    assign op_o = '{opcode:     opcode,
                    chan:       chan_reg,
                    data:       data,
                    bend_range: range_reg,
                    expr_on:    expr_on_reg,
                    expr_level: expr_level_reg};

    // Parser registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_STATUS;
            chan_reg       <= '0;
            nrpn_lo_reg    <= '0;
            nrpn_hi_reg    <= '0;
            rpn_lo_reg     <= '0;
            rpn_hi_reg     <= '0;
            registered_reg <= 1'b0;
            range_reg      <= mcvp_pkg::BEND_RANGE_RESET;
            expr_on_reg    <= 1'b0;
            expr_level_reg <= '0;
        end else if (in_accept) begin
            state_reg      <= state_next;
            chan_reg       <= chan_next;
            nrpn_lo_reg    <= nrpn_lo_next;
            nrpn_hi_reg    <= nrpn_hi_next;
            rpn_lo_reg     <= rpn_lo_next;
            rpn_hi_reg     <= rpn_hi_next;
            registered_reg <= registered_next;
            range_reg      <= range_next;
            expr_on_reg    <= expr_on_next;
            expr_level_reg <= expr_level_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/mcvp_voice.sv @@
// ============================================================================
// MIDI channel voice parser - voice stage
// Per-channel voice memory with read-modify-write, pitch arithmetic and the
// registered result output.
// ============================================================================
`default_nettype none

module mcvp_voice #(
    parameter int NUM_CHANNELS = mcvp_pkg::DEFAULT_NUM_CHANNELS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                op_valid,
    input  wire mcvp_pkg::voice_op_t op_i,
    output logic                     op_ready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [47:0]              m_tdata,
    output logic                     m_tuser
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Voice memory and one valid bit per channel (unwritten reads as reset entry)
    mcvp_pkg::voice_entry_t   entry_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  valid_reg;

    // Stage 1: operation plus read data
    logic                     s1_valid_reg;
    mcvp_pkg::voice_op_t      s1_op_reg;
    mcvp_pkg::voice_entry_t   rd_entry_reg;
    logic                     rd_valid_reg;

    // Last write, forwarded to a read that overlapped it
    logic                     lw_valid_reg;
    logic [AW-1:0]            lw_addr_reg;
    mcvp_pkg::voice_entry_t   lw_entry_reg;

    // Output register
    logic                              m_valid_reg;
    logic [mcvp_pkg::CHAN_W-1:0]       m_chan_reg;
    logic                              m_tie_reg;
    logic [mcvp_pkg::PITCH_W-1:0]      m_pitch_reg;
    logic [mcvp_pkg::DATA_W-1:0]       m_vol_reg;
    logic [mcvp_pkg::DATA_W-1:0]       m_param_reg;
    logic [mcvp_pkg::DATA_W-1:0]       m_value_reg;

    logic [AW-1:0]            rd_addr, wr_addr;
    mcvp_pkg::voice_entry_t   cur_entry, new_entry;
    logic                     wr_en, emit, tie, s1_move, out_free;
    logic [mcvp_pkg::DATA_W-1:0] out_vol;
    logic signed [14:0]       bend_off;
    logic signed [7:0]        range_s;
    logic signed [22:0]       bend_term, note_term;
    logic [mcvp_pkg::PITCH_W-1:0] pitch;

    assign rd_addr = op_i.chan[AW-1:0];
    assign wr_addr = s1_op_reg.chan[AW-1:0];

    // Current entry: forwarded write, stored entry or reset value
    always_comb begin
        if (lw_valid_reg && lw_addr_reg == wr_addr) begin
            cur_entry = lw_entry_reg;
        end else if (rd_valid_reg) begin
            cur_entry = rd_entry_reg;
        end else begin
            cur_entry = mcvp_pkg::ENTRY_RESET;
        end
    end

    // Modify
    always_comb begin
        new_entry = cur_entry;
        wr_en     = 1'b0;
        emit      = 1'b0;
        tie       = 1'b0;
        out_vol   = cur_entry.volume;
        unique case (s1_op_reg.opcode)
            mcvp_pkg::OP_NONE: ;
            mcvp_pkg::OP_NOTE: begin
                new_entry.note = s1_op_reg.data;
                wr_en          = 1'b1;
            end
            mcvp_pkg::OP_ON_VEL: begin
                new_entry.volume = s1_op_reg.data;
                out_vol          = s1_op_reg.data;
                wr_en            = 1'b1;
                emit             = 1'b1;
            end
            mcvp_pkg::OP_OFF_VEL: begin
                new_entry.volume = '0;
                out_vol          = '0;
                wr_en            = 1'b1;
                emit             = 1'b1;
            end
            mcvp_pkg::OP_BEND_LO: begin
                new_entry.bend = {7'd0, s1_op_reg.data};
                wr_en          = 1'b1;
            end
            mcvp_pkg::OP_BEND_HI: begin
                new_entry.bend = {s1_op_reg.data, cur_entry.bend[6:0]};
                wr_en          = 1'b1;
                emit           = 1'b1;
            end
            mcvp_pkg::OP_PRESS: begin
                // pressure only on a sounding voice
                if (cur_entry.volume != '0) begin
                    new_entry.volume = s1_op_reg.data;
                    out_vol          = s1_op_reg.data;
                    wr_en            = 1'b1;
                    emit             = 1'b1;
                end
            end
            mcvp_pkg::OP_TIE: begin
                emit = 1'b1;
                tie  = 1'b1;
            end
            default: ;
        endcase
    end

    // pitch = note*8192 + range*(bend-8192)
    always_comb begin
        bend_off  = $signed({1'b0, new_entry.bend}) - $signed({1'b0, mcvp_pkg::BEND_CENTRE});
        range_s   = $signed({1'b0, s1_op_reg.bend_range});
        bend_term = range_s * bend_off;
        note_term = $signed({3'd0, new_entry.note, 13'd0});
        pitch     = mcvp_pkg::PITCH_W'(note_term + bend_term);
    end

    // Stage hand-off
    assign out_free = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && (!emit || out_free);
    assign op_ready = !s1_valid_reg || s1_move;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (op_valid) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move && wr_en) begin
                lw_valid_reg       <= 1'b1;
                valid_reg[wr_addr] <= 1'b1;
            end
            if (s1_move && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Memory read and write-back, stage payload
    always_ff @(posedge aclk) begin
        if (op_valid) begin
            s1_op_reg    <= op_i;
            rd_entry_reg <= entry_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (s1_move && wr_en) begin
            entry_mem[wr_addr] <= new_entry;
            lw_addr_reg        <= wr_addr;
            lw_entry_reg       <= new_entry;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s1_move && emit) begin
            m_chan_reg <= s1_op_reg.chan;
            m_tie_reg  <= tie;
            if (tie) begin
                m_pitch_reg <= '0;
                m_vol_reg   <= '0;
                m_param_reg <= '0;
                m_value_reg <= '0;
            end else begin
                m_pitch_reg <= pitch;
                m_vol_reg   <= out_vol;
                m_param_reg <= s1_op_reg.expr_on ? mcvp_pkg::CC_EXPRESSION : '0;
                m_value_reg <= s1_op_reg.expr_level;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_tie_reg;
    assign m_tdata  = {1'b0, m_value_reg, m_param_reg, m_vol_reg, m_pitch_reg, m_chan_reg};

endmodule

`default_nettype wire

@@ sv/midi_channel_voice_parser.sv @@
// ============================================================================
// MIDI channel voice parser - top level
// Parses a MIDI byte stream into per-channel voice updates and tie events.
// ============================================================================
// Usage:
//   s_ channel: one MIDI byte per transaction in s_tdata. Status bytes select
//   the message kind and channel; data bytes follow with running status.
//   m_ channel: one voice update per completed note-on, note-off, pitch bend
//   or channel pressure message (pressure only on a voice with nonzero
//   volume), or a tie event (m_tuser high) on NRPN 9/71 data entry.
//   Throughput: one byte per cycle while no result stalls, set by the
//   read-modify-write of the voice memory; a write is forwarded to an
//   immediately following read of the same channel.
//   Path: the byte that completes a message is registered in the voice stage,
//   then its result in the output register that drives m_tvalid.
//   Reset: s_tready is low, parse state waits for a status byte, bend range
//   is 2, every channel reads as note 0, volume 0, bend 8192 until first
//   written (one valid bit per channel, no clearing pass).
//   Stall: a result waits in the output register; bytes that complete no
//   message keep flowing, but the next byte that completes one is held in
//   the voice stage and s_tready stays low until m_tready frees the output.
// ============================================================================
`default_nettype none

module midi_channel_voice_parser #(
    parameter int NUM_CHANNELS = mcvp_pkg::DEFAULT_NUM_CHANNELS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [3:0] voice_channel, [25:4] pitch_fixed,
                                        // [32:26] volume_level, [39:33] expr_param,
                                        // [46:40] expr_value, [47] zero
    output logic             m_tuser    // [0] tie_marker
);

    logic                 accept;
    logic                 op_ready;
    mcvp_pkg::voice_op_t  op;

    // no transaction is taken while in reset
    assign s_tready = op_ready && aresetn;
    assign accept   = s_tvalid && s_tready;

    // Byte decoder
    mcvp_decode #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_byte   (s_tdata),
        .op_o      (op)
    );

    // Voice memory stage and output register
    mcvp_voice #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_voice (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (accept),
        .op_i     (op),
        .op_ready (op_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ sv/mcvp_checker.sv @@
// ============================================================================
// MIDI channel voice parser - port checker
// Concurrent assertions on the top-level ports, attached by bind.
// ============================================================================
`default_nettype none

module mcvp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser
);

    // Reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result presented straight after reset");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A tie event carries only its channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[47:4] == '0)
        else $error("tie event with nonzero fields");

    // A new result follows an accepted input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && aresetn, 2))
        else $error("result without a matching input transaction");

endmodule

bind midi_channel_voice_parser mcvp_checker u_mcvp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ sim/midi_channel_voice_parser_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// MIDI channel voice parser - self-checking testbench
// Streams MIDI bytes into the parser and tracks the per-channel voice state
// alongside it. Every voice update or tie event leaving the block is checked
// field by field against the oldest predicted one. A short directed part hits
// the extremes and special messages; a long random part follows.
// ============================================================================

module midi_channel_voice_parser_test;

    localparam int QUIET_LIMIT = 2000;

    // Status kinds the parser does not decode
    localparam logic [3:0] STAT_POLY_PRESS  = 4'hA;
    localparam logic [3:0] STAT_PROG_CHANGE = 4'hC;
    localparam logic [3:0] STAT_SYSTEM      = 4'hF;

    // Parser states of the tracking model
    typedef enum logic [3:0] {
        PS_STATUS,
        PS_ON_NOTE,
        PS_ON_VEL,
        PS_OFF_NOTE,
        PS_OFF_VEL,
        PS_BEND_LO,
        PS_BEND_HI,
        PS_CTRL_NUM,
        PS_NRPN_LO,
        PS_NRPN_HI,
        PS_DATA_ENTRY,
        PS_RPN_LO,
        PS_RPN_HI,
        PS_PRESSURE,
        PS_EXPRESSION
    } parse_state_t;

    // One voice update or tie event
    typedef struct packed {
        logic [3:0]         chan;
        logic               tie;
        logic signed [21:0] pitch;
        logic [6:0]         volume;
        logic [6:0]         expr_param;
        logic [6:0]         expr_value;
    } voice_update_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;
    logic        m_tuser;

    // Tracked voice state
    parse_state_t pstate         = PS_STATUS;
    logic [3:0]   cur_chan       = '0;
    logic [6:0]   chan_note   [16] = '{default: '0};
    logic [6:0]   chan_volume [16] = '{default: '0};
    logic [13:0]  chan_bend   [16] = '{default: mcvp_pkg::BEND_CENTRE};
    logic [6:0]   bend_range     = mcvp_pkg::BEND_RANGE_RESET;
    logic [6:0]   nrpn_lsb       = '0;
    logic [6:0]   nrpn_msb       = '0;
    logic [6:0]   rpn_lsb        = '0;
    logic [6:0]   rpn_msb        = '0;
    logic         key_registered = 1'b0;
    logic [6:0]   expr_param     = '0;
    logic [6:0]   expr_value     = '0;

    voice_update_t pending_updates[$];
    int            mismatches = 0;
    int            bytes_sent = 0;
    int            quiet_cycles = 0;
    int            stall_left = 0;
    bit            idle_on = 1'b1;

    midi_channel_voice_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Voice state tracking
    // ------------------------------------------------------------------------
    task automatic queue_voice_update(input logic [3:0] ch, input logic [6:0] level);
        voice_update_t u;
        int            p;
        p = int'(chan_note[ch]) * 8192 + int'(bend_range) * (int'(chan_bend[ch]) - 8192);
        u.chan       = ch;
        u.tie        = 1'b0;
        u.pitch      = p[21:0];
        u.volume     = level;
        u.expr_param = expr_param;
        u.expr_value = expr_value;
        pending_updates.push_back(u);
    endtask

    task automatic track_rx_byte(input logic [7:0] rx);
        logic [6:0]    d;
        logic [3:0]    ch;
        voice_update_t tie_evt;
        d  = rx[6:0];
        ch = cur_chan;
        // bends held at centre until the first recognised status
        if (pstate == PS_STATUS)
            foreach (chan_bend[i]) chan_bend[i] = mcvp_pkg::BEND_CENTRE;
        if (rx[7]) begin
            cur_chan = rx[3:0];
            case (rx[7:4])
                mcvp_pkg::STAT_NOTE_OFF: pstate = PS_OFF_NOTE;
                mcvp_pkg::STAT_NOTE_ON:  pstate = PS_ON_NOTE;
                mcvp_pkg::STAT_CTRL:     pstate = PS_CTRL_NUM;
                mcvp_pkg::STAT_PRESSURE: pstate = PS_PRESSURE;
                mcvp_pkg::STAT_BEND:     pstate = PS_BEND_LO;
                default: ;
            endcase
        end else begin
            case (pstate)
                PS_ON_NOTE: begin
                    chan_note[ch] = d;
                    pstate = PS_ON_VEL;
                end
                PS_ON_VEL: begin
                    pstate = PS_ON_NOTE;
                    chan_volume[ch] = d;
                    queue_voice_update(ch, d);
                end
                PS_OFF_NOTE: begin
                    chan_note[ch] = d;
                    pstate = PS_OFF_VEL;
                end
                PS_OFF_VEL: begin
                    pstate = PS_OFF_NOTE;
                    chan_volume[ch] = '0;
                    queue_voice_update(ch, '0);
                end
                PS_BEND_LO: begin
                    chan_bend[ch] = {7'd0, d};
                    pstate = PS_BEND_HI;
                end
                PS_BEND_HI: begin
                    pstate = PS_BEND_LO;
                    chan_bend[ch] = {d, chan_bend[ch][6:0]};
                    queue_voice_update(ch, chan_volume[ch]);
                end
                PS_CTRL_NUM: begin
                    case (d)
                        mcvp_pkg::CC_NRPN_LSB:   pstate = PS_NRPN_LO;
                        mcvp_pkg::CC_NRPN_MSB:   pstate = PS_NRPN_HI;
                        mcvp_pkg::CC_RPN_LSB:    pstate = PS_RPN_LO;
                        mcvp_pkg::CC_RPN_MSB:    pstate = PS_RPN_HI;
                        mcvp_pkg::CC_DATA:       pstate = PS_DATA_ENTRY;
                        mcvp_pkg::CC_EXPRESSION: pstate = PS_EXPRESSION;
                        default: ;
                    endcase
                end
                PS_NRPN_LO: begin
                    key_registered = 1'b0;
                    nrpn_lsb = d;
                end
                PS_NRPN_HI: begin
                    key_registered = 1'b0;
                    nrpn_msb = d;
                end
                PS_RPN_LO: begin
                    key_registered = 1'b1;
                    rpn_lsb = d;
                end
                PS_RPN_HI: begin
                    key_registered = 1'b1;
                    rpn_msb = d;
                end
                PS_DATA_ENTRY: begin
                    if (key_registered && rpn_lsb == '0 && rpn_msb == '0) begin
                        bend_range = d;
                    end else if (!key_registered && nrpn_lsb == mcvp_pkg::TIE_KEY_LSB &&
                                 nrpn_msb == mcvp_pkg::TIE_KEY_MSB) begin
                        tie_evt      = '0;
                        tie_evt.chan = ch;
                        tie_evt.tie  = 1'b1;
                        pending_updates.push_back(tie_evt);
                    end
                end
                PS_PRESSURE: begin
                    // silent voices ignore pressure
                    if (chan_volume[ch] != '0) begin
                        chan_volume[ch] = d;
                        queue_voice_update(ch, d);
                    end
                end
                PS_EXPRESSION: begin
                    expr_param = mcvp_pkg::CC_EXPRESSION;
                    expr_value = d;
                end
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // One byte per transaction; valid stays high between back-to-back bytes
    task automatic send_byte(input logic [7:0] rx);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_rx_byte(rx);
        bytes_sent++;
    endtask

    // Hold off until every predicted update has left the block
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_updates.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [6:0] any_data();
        case ($urandom_range(0, 5))
            0:       return 7'h00;
            1:       return 7'h7F;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // Half the time the key value that means something to the parser
    function automatic logic [6:0] key_value(input logic [6:0] favoured);
        return ($urandom_range(0, 1) == 0) ? favoured : any_data();
    endfunction

    task automatic send_control_change(input logic [3:0] ch);
        logic [6:0] ctrl;
        logic [6:0] favoured;
        case ($urandom_range(0, 6))
            0: begin
                // full RPN 0/0 bend range set
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                send_byte({1'b0, mcvp_pkg::CC_RPN_LSB});
                send_byte({1'b0, key_value(7'd0)});
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                send_byte({1'b0, mcvp_pkg::CC_RPN_MSB});
                send_byte({1'b0, key_value(7'd0)});
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                send_byte({1'b0, mcvp_pkg::CC_DATA});
                send_byte({1'b0, any_data()});
            end
            1: begin
                // full NRPN tie key plus data entry
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                send_byte({1'b0, mcvp_pkg::CC_NRPN_LSB});
                send_byte({1'b0, key_value(mcvp_pkg::TIE_KEY_LSB)});
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                send_byte({1'b0, mcvp_pkg::CC_NRPN_MSB});
                send_byte({1'b0, key_value(mcvp_pkg::TIE_KEY_MSB)});
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                send_byte({1'b0, mcvp_pkg::CC_DATA});
                repeat ($urandom_range(1, 2)) send_byte({1'b0, any_data()});
            end
            2: begin
                // single key half
                case ($urandom_range(0, 3))
                    0: begin
                        ctrl     = mcvp_pkg::CC_NRPN_LSB;
                        favoured = mcvp_pkg::TIE_KEY_LSB;
                    end
                    1: begin
                        ctrl     = mcvp_pkg::CC_NRPN_MSB;
                        favoured = mcvp_pkg::TIE_KEY_MSB;
                    end
                    2: begin
                        ctrl     = mcvp_pkg::CC_RPN_LSB;
                        favoured = 7'd0;
                    end
                    default: begin
                        ctrl     = mcvp_pkg::CC_RPN_MSB;
                        favoured = 7'd0;
                    end
                endcase
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                send_byte({1'b0, ctrl});
                repeat ($urandom_range(1, 2)) send_byte({1'b0, key_value(favoured)});
            end
            3: begin
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                send_byte({1'b0, mcvp_pkg::CC_DATA});
                repeat ($urandom_range(1, 3)) send_byte({1'b0, any_data()});
            end
            4: begin
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                send_byte({1'b0, mcvp_pkg::CC_EXPRESSION});
                repeat ($urandom_range(1, 2)) send_byte({1'b0, any_data()});
            end
            default: begin
                // unrecognised controllers, then maybe a real one
                send_byte({mcvp_pkg::STAT_CTRL, ch});
                repeat ($urandom_range(1, 2)) send_byte({1'b0, any_data()});
                if ($urandom_range(0, 1) == 0) begin
                    send_byte({1'b0, mcvp_pkg::CC_EXPRESSION});
                    send_byte({1'b0, any_data()});
                end
            end
        endcase
    endtask

    task automatic send_random_message();
        logic [3:0] ch;
        ch = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
                send_byte({mcvp_pkg::STAT_NOTE_ON, ch});
                repeat ($urandom_range(1, 3)) begin
                    send_byte({1'b0, any_data()});
                    send_byte({1'b0, any_data()});
                end
            end
            4, 5: begin
                send_byte({mcvp_pkg::STAT_NOTE_OFF, ch});
                repeat ($urandom_range(1, 2)) begin
                    send_byte({1'b0, any_data()});
                    send_byte({1'b0, any_data()});
                end
            end
            6, 7, 8: begin
                send_byte({mcvp_pkg::STAT_BEND, ch});
                repeat ($urandom_range(1, 3)) begin
                    send_byte({1'b0, any_data()});
                    send_byte({1'b0, any_data()});
                end
            end
            9, 10: begin
                send_byte({mcvp_pkg::STAT_PRESSURE, ch});
                repeat ($urandom_range(1, 3)) send_byte({1'b0, any_data()});
            end
            11, 12, 13, 14, 15: send_control_change(ch);
            16: begin
                // status kinds the parser does not decode
                case ($urandom_range(0, 2))
                    0:       send_byte({STAT_POLY_PRESS, ch});
                    1:       send_byte({STAT_PROG_CHANGE, ch});
                    default: send_byte({STAT_SYSTEM, ch});
                endcase
                repeat ($urandom_range(0, 2)) send_byte({1'b0, any_data()});
            end
            17: send_byte(8'($urandom_range(0, 255)));
            18: repeat ($urandom_range(1, 4)) send_byte({1'b0, any_data()});
            default: begin
                // message cut short by a new status
                send_byte({4'($urandom_range(8, 15)), ch});
                send_byte({1'b0, any_data()});
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Data before any status and an undecoded status are both ignored
    task automatic test_stray_bytes();
        send_byte(8'h05);
        send_byte({STAT_SYSTEM, 4'h3});
    endtask

    // RPN 0/0 data entry sets the widest bend range; zero bend gives lowest pitch
    task automatic test_bend_range();
        send_byte({mcvp_pkg::STAT_CTRL, 4'h0});
        send_byte({1'b0, mcvp_pkg::CC_RPN_LSB});
        send_byte(8'h00);
        send_byte({mcvp_pkg::STAT_CTRL, 4'h0});
        send_byte({1'b0, mcvp_pkg::CC_DATA});
        send_byte(8'h7F);
        send_byte({mcvp_pkg::STAT_BEND, 4'h0});
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // Top note at full velocity, full bend up, then a note-off
    task automatic test_notes();
        send_byte({mcvp_pkg::STAT_NOTE_ON, 4'hF});
        send_byte(8'h7F);
        send_byte(8'h7F);
        send_byte({mcvp_pkg::STAT_BEND, 4'hF});
        send_byte(8'h7F);
        send_byte(8'h7F);
        send_byte({mcvp_pkg::STAT_NOTE_OFF, 4'h0});
        send_byte(8'h55);
        send_byte(8'h00);
    endtask

    // Pressure silences channel 15, after which further pressure is dropped
    task automatic test_pressure();
        send_byte({mcvp_pkg::STAT_PRESSURE, 4'hF});
        send_byte(8'h00);
        send_byte(8'h20);
    endtask

    // Unknown controller, expression, NRPN tie and an undecoded status mid-stream
    task automatic test_controllers();
        send_byte({mcvp_pkg::STAT_CTRL, 4'hF});
        send_byte(8'h14);
        send_byte({1'b0, mcvp_pkg::CC_EXPRESSION});
        send_byte(8'h55);
        send_byte({mcvp_pkg::STAT_CTRL, 4'h2});
        send_byte({1'b0, mcvp_pkg::CC_NRPN_LSB});
        send_byte({1'b0, mcvp_pkg::TIE_KEY_LSB});
        send_byte({mcvp_pkg::STAT_CTRL, 4'h2});
        send_byte({1'b0, mcvp_pkg::CC_NRPN_MSB});
        send_byte({1'b0, mcvp_pkg::TIE_KEY_MSB});
        send_byte({mcvp_pkg::STAT_CTRL, 4'h2});
        send_byte({1'b0, mcvp_pkg::CC_DATA});
        send_byte(8'h11);
        send_byte({STAT_SYSTEM, 4'hA});
        send_byte(8'h00);
    endtask

    task automatic test_random_stream(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target - count / 2) send_random_message();
        wait_until_drained();
        while (bytes_sent < target - 120) send_random_message();
        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        while (bytes_sent < target) send_random_message();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_stray_bytes();
        test_bend_range();
        test_notes();
        test_pressure();
        test_controllers();
        test_random_stream(650);
        wait_until_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 16);
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        voice_update_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_updates.pop_front();
                compare_field("voice_channel", want.chan, m_tdata[3:0]);
                compare_field("tie_marker", want.tie, m_tuser);
                compare_field("pitch_fixed", $signed(want.pitch), $signed(m_tdata[25:4]));
                compare_field("volume_level", want.volume, m_tdata[32:26]);
                compare_field("expr_param", want.expr_param, m_tdata[39:33]);
                compare_field("expr_value", want.expr_value, m_tdata[46:40]);
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired, %0d updates outstanding",
                     $time, pending_updates.size());
            $display("simulation failed");
            $finish;
        end
    end

endmodule

@@ files.f @@
sv/mcvp_pkg.sv
sv/mcvp_decode.sv
sv/mcvp_voice.sv
sv/midi_channel_voice_parser.sv
sv/mcvp_checker.sv
sim/midi_channel_voice_parser_test.sv
